>>> rtl/core/dife_pkg.sv
package dife_pkg;

  localparam int CHAR_W        = 8;
  localparam int VALUE_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int LEN_W         = 4;
  localparam int MAX_DELIM_LEN = 8;
  localparam int MAX_TOKEN_LEN = 32;
  localparam int COUNT_W       = 6;
  localparam int MAG_W         = 16;
  localparam int MAG_CAP       = 32769;

  typedef enum logic [1:0] {
    OUTCOME_VALID = 2'd0,
    OUTCOME_NULL  = 2'd1,
    OUTCOME_ERROR = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_PATTERN = 2'd0,
    REG_START_LENGTH  = 2'd1,
    REG_STOP_PATTERN  = 2'd2,
    REG_STOP_LENGTH   = 2'd3
  } cfg_reg_t;

endpackage

>>> rtl/core/dife_in_if.sv
interface dife_in_if;
  import dife_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

>>> rtl/core/dife_out_if.sv
interface dife_out_if;
  import dife_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  outcome_t                  outcome;

  modport source (output valid, output value, output outcome, input ready);
  modport sink (input valid, input value, input outcome, output ready);
endinterface

>>> rtl/core/delimited_int16_field_extractor.sv
// Pulls a signed 16-bit decimal field out of a zero-terminated character stream, one
// character beat per clock unless the result sink stalls. The field lies between the first
// start delimiter and the first stop delimiter after it (each up to 8 bytes, set through
// the cfg port while the block is idle, which the block does not enforce); leading
// whitespace and one sign are allowed. Only the zero terminator produces a result beat,
// which appears from the output register in the cycle after the terminator is taken:
// outcome 0 carries the value, 1 means a delimiter is missing or the field is empty, 2
// means a malformed, too long (32 characters or more) or out-of-range field. Input is
// still taken while a result waits if the sink is ready. The 8-byte delimiter window
// compare and the times-ten accumulate are combinational.
module delimited_int16_field_extractor (
  input  logic                                clk,
  input  logic                                rst_n,
  dife_in_if.sink                             in_ch,
  dife_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [dife_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dife_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dife_pkg::*;

  localparam int WIN_IDX_W = $clog2(MAX_DELIM_LEN);
  localparam int PROD_W    = MAG_W + 3;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(MAX_TOKEN_LEN + MAX_DELIM_LEN);

  typedef enum logic [1:0] {
    SCAN_SEEK_START,
    SCAN_SEEK_STOP,
    SCAN_DONE
  } scan_t;

  typedef enum logic [1:0] {
    NUM_LEAD,
    NUM_SIGN,
    NUM_DIGITS
  } num_t;

  typedef logic [MAX_DELIM_LEN-1:0][CHAR_W-1:0] win_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_DATA_W-1:0] pat,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] res;
    logic             found;
    n     = (len > LEN_W'(MAX_DELIM_LEN)) ? LEN_W'(MAX_DELIM_LEN) : len;
    res   = n;
    found = 1'b0;
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      if (!found && LEN_W'(i) < n && pat[CHAR_W*i +: CHAR_W] == '0) begin
        res   = LEN_W'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // window entry 0 is the newest character; pattern byte 0 is the oldest of the match
  function automatic logic win_match(input logic [CFG_DATA_W-1:0] pat,
                                     input logic [LEN_W-1:0] len,
                                     input win_t win);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_DELIM_LEN; i++) begin
      if (LEN_W'(i) < len &&
          win[WIN_IDX_W'(len - LEN_W'(i) - LEN_W'(1))] != pat[CHAR_W*i +: CHAR_W]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  logic [CFG_DATA_W-1:0] start_pat_r, stop_pat_r;
  logic [LEN_W-1:0]      start_len_r, stop_len_r;

  win_t             win_r, win_nxt;
  scan_t            scan_r, scan_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] tok_len_r, tok_len_nxt;
  num_t             num_r, num_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             bad_r, bad_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  outcome_t                  out_outcome_r, out_outcome_nxt;

  logic             in_fire;
  logic             is_term;
  logic [CHAR_W-1:0] ch;
  logic [LEN_W-1:0] ls, lp;
  logic             start_hit, stop_hit;
  logic             run_stop;
  logic [COUNT_W-1:0] cnt_inc;
  logic [CHAR_W-1:0] fb;
  logic             fb_digit, fb_space, fb_sign;
  logic [PROD_W-1:0] prod;
  logic             range_bad;
  outcome_t         term_outcome;
  logic [VALUE_W-1:0] term_value;

  assign in_ch.ready    = ~out_valid_r | out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.value   = out_value_r;
  assign out_ch.outcome = out_outcome_r;

  assign in_fire = in_ch.valid & in_ch.ready;
  assign ch      = in_ch.character;
  assign is_term = (ch == '0);
  assign ls      = eff_len(start_pat_r, start_len_r);
  assign lp      = eff_len(stop_pat_r, stop_len_r);

  always_comb begin
    win_nxt = {win_r[MAX_DELIM_LEN-2:0], ch};
  end

  assign start_hit = win_match(start_pat_r, ls, win_nxt);
  assign stop_hit  = win_match(stop_pat_r, lp, win_nxt);

  // result at the terminator, from the registered scan state
  always_comb begin
    range_bad  = neg_r ? (mag_r > MAG_W'(32768)) : (mag_r > MAG_W'(32767));
    term_value = '0;
    if (scan_r != SCAN_DONE) begin
      term_outcome = OUTCOME_NULL;
    end else if (tok_len_r >= COUNT_W'(MAX_TOKEN_LEN)) begin
      term_outcome = OUTCOME_ERROR;
    end else if (tok_len_r == '0) begin
      term_outcome = OUTCOME_NULL;
    end else if (bad_r || num_r != NUM_DIGITS || range_bad) begin
      term_outcome = OUTCOME_ERROR;
    end else begin
      term_outcome = OUTCOME_VALID;
      term_value   = neg_r ? (VALUE_W'(0) - mag_r) : mag_r;
    end
  end

  always_comb begin
    scan_nxt    = scan_r;
    count_nxt   = count_r;
    tok_len_nxt = tok_len_r;
    num_nxt     = num_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    bad_nxt     = bad_r;
    run_stop    = 1'b0;
    cnt_inc     = '0;
    fb          = win_nxt[WIN_IDX_W'(lp - LEN_W'(1))];
    fb_digit    = (fb >= 8'h30) && (fb <= 8'h39);
    fb_space    = (fb == 8'h20) || ((fb >= 8'h09) && (fb <= 8'h0d));
    fb_sign     = (fb == 8'h2b) || (fb == 8'h2d);
    prod        = '0;

    out_valid_nxt   = out_ch.ready ? 1'b0 : out_valid_r;
    out_value_nxt   = out_value_r;
    out_outcome_nxt = out_outcome_r;

    if (in_fire && is_term) begin
      out_valid_nxt   = 1'b1;
      out_value_nxt   = term_value;
      out_outcome_nxt = term_outcome;
    end

    if (in_fire) begin
      if (scan_r == SCAN_SEEK_START || is_term) begin
        count_nxt   = '0;
        tok_len_nxt = '0;
        num_nxt     = NUM_LEAD;
        mag_nxt     = '0;
        neg_nxt     = 1'b0;
        bad_nxt     = 1'b0;
      end
      if (is_term) begin
        scan_nxt = SCAN_SEEK_START;
      end else if (scan_r == SCAN_SEEK_START) begin
        if (ls == '0) begin
          if (lp == '0) begin
            scan_nxt = SCAN_DONE;
          end else begin
            scan_nxt = SCAN_SEEK_STOP;
            run_stop = 1'b1;
          end
        end else if (start_hit) begin
          scan_nxt = (lp == '0) ? SCAN_DONE : SCAN_SEEK_STOP;
        end else begin
          scan_nxt = SCAN_SEEK_START;
        end
      end else if (scan_r == SCAN_SEEK_STOP) begin
        run_stop = 1'b1;
      end
    end

    if (run_stop) begin
      cnt_inc   = (count_nxt < COUNT_CAP) ? count_nxt + COUNT_W'(1) : count_nxt;
      count_nxt = cnt_inc;
      if (lp == '0) begin
        scan_nxt    = SCAN_DONE;
        tok_len_nxt = cnt_inc - COUNT_W'(1);
      end else if (cnt_inc >= COUNT_W'(lp) && stop_hit) begin
        scan_nxt    = SCAN_DONE;
        tok_len_nxt = cnt_inc - COUNT_W'(lp);
      end else if (cnt_inc >= COUNT_W'(lp) && !bad_nxt) begin
        if (fb_digit) begin
          prod    = (PROD_W'(mag_nxt) << 3) + (PROD_W'(mag_nxt) << 1)
                  + PROD_W'(fb - 8'h30);
          mag_nxt = (prod > PROD_W'(MAG_CAP)) ? MAG_W'(MAG_CAP) : MAG_W'(prod);
          num_nxt = NUM_DIGITS;
        end else if (num_nxt == NUM_LEAD && fb_space) begin
          num_nxt = NUM_LEAD;
        end else if (num_nxt == NUM_LEAD && fb_sign) begin
          neg_nxt = (fb == 8'h2d);
          num_nxt = NUM_SIGN;
        end else begin
          bad_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pat_r <= '0;
      start_len_r <= '0;
      stop_pat_r  <= '0;
      stop_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_PATTERN: start_pat_r <= cfg_wdata;
        REG_START_LENGTH:  start_len_r <= cfg_wdata[LEN_W-1:0];
        REG_STOP_PATTERN:  stop_pat_r  <= cfg_wdata;
        REG_STOP_LENGTH:   stop_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      scan_r      <= SCAN_SEEK_START;
      count_r     <= '0;
      tok_len_r   <= '0;
      num_r       <= NUM_LEAD;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        win_r <= is_term ? win_t'('0) : win_nxt;
      end
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      tok_len_r   <= tok_len_nxt;
      num_r       <= num_nxt;
      mag_r       <= mag_nxt;
      neg_r       <= neg_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r   <= out_value_nxt;
    out_outcome_r <= out_outcome_nxt;
  end

endmodule

>>> tb/dife_tb_pkg.sv
package dife_tb_pkg;
  import dife_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // usable delimiter bytes: length clipped to the window, cut at the first zero byte
  function automatic int delim_span(logic [CFG_DATA_W-1:0] pattern, logic [LEN_W-1:0] length);
    int n;
    int i;
    n = (int'(length) > MAX_DELIM_LEN) ? MAX_DELIM_LEN : int'(length);
    for (i = 0; i < n; i++) begin
      if (pattern[8*i +: 8] == 8'h00) return i;
    end
    return n;
  endfunction

endpackage

>>> tb/dife_field_checker.sv
module dife_field_checker
  import dife_pkg::*;
  import dife_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  dife_in_if                    in_mon,
  dife_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    fields_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    outcome_t                  outcome;
  } field_result_t;

  typedef enum logic [1:0] {SEEK_START, SEEK_STOP, STOP_FOUND} scan_state_t;
  typedef enum logic [1:0] {LEAD_SPACE, AFTER_SIGN, IN_DIGITS} num_state_t;

  logic [CFG_DATA_W-1:0] start_pat;
  logic [CFG_DATA_W-1:0] stop_pat;
  logic [LEN_W-1:0]      start_len;
  logic [LEN_W-1:0]      stop_len;

  logic [7:0]    recent [8];
  scan_state_t   scan;
  num_state_t    num;
  int            since_start;
  int            token_len;
  int            magnitude;
  bit            negative;
  bit            malformed;
  field_result_t expected_fields[$];
  int            n_mismatch;

  // newest character sits in recent[0]; pattern byte 0 is the oldest of the window
  function automatic bit window_hit(logic [CFG_DATA_W-1:0] pattern, int len);
    int i;
    for (i = 0; i < len; i++) begin
      if (recent[len - 1 - i] != pattern[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void start_token();
    scan        = SEEK_STOP;
    since_start = 0;
    token_len   = 0;
    num         = LEAD_SPACE;
    magnitude   = 0;
    negative    = 1'b0;
    malformed   = 1'b0;
  endfunction

  function automatic void clear_scan();
    int i;
    for (i = 0; i < 8; i++) recent[i] = 8'h00;
    start_token();
    scan = SEEK_START;
  endfunction

  function automatic void take_token_char(logic [7:0] c);
    bit is_digit;
    bit is_space;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_space = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    if (malformed) return;
    if (is_digit) begin
      magnitude = magnitude * 10 + int'(c) - int'(CH_ZERO);
      if (magnitude > MAG_CAP) magnitude = MAG_CAP;
      num = IN_DIGITS;
    end else if (num == LEAD_SPACE && is_space) begin
    end else if (num == LEAD_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
      negative = (c == CH_MINUS);
      num      = AFTER_SIGN;
    end else begin
      malformed = 1'b1;
    end
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int            ls;
    int            lp;
    int            i;
    logic [31:0]   wide;
    field_result_t res;
    ls = delim_span(start_pat, start_len);
    lp = delim_span(stop_pat, stop_len);
    if (c == 8'h00) begin
      res.value   = '0;
      res.outcome = OUTCOME_NULL;
      if (scan == STOP_FOUND) begin
        if (token_len >= MAX_TOKEN_LEN) res.outcome = OUTCOME_ERROR;
        else if (token_len == 0) res.outcome = OUTCOME_NULL;
        else if (malformed || num != IN_DIGITS) res.outcome = OUTCOME_ERROR;
        else if (magnitude > (negative ? 32768 : 32767)) res.outcome = OUTCOME_ERROR;
        else begin
          wide        = negative ? 32'(0 - magnitude) : 32'(magnitude);
          res.value   = wide[VALUE_W-1:0];
          res.outcome = OUTCOME_VALID;
        end
      end
      expected_fields.push_back(res);
      clear_scan();
      return;
    end
    for (i = 7; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = c;
    if (scan == SEEK_START) begin
      if (ls == 0) begin
        // no start delimiter: this character already belongs to the token region
        start_token();
        if (lp == 0) begin
          scan = STOP_FOUND;
          return;
        end
      end else begin
        if (window_hit(start_pat, ls)) begin
          start_token();
          if (lp == 0) scan = STOP_FOUND;
        end
        return;
      end
    end
    if (scan == SEEK_STOP) begin
      if (since_start < MAX_TOKEN_LEN + MAX_DELIM_LEN) since_start++;
      if (lp == 0) begin
        scan      = STOP_FOUND;
        token_len = since_start - 1;
      end else if (since_start >= lp && window_hit(stop_pat, lp)) begin
        scan      = STOP_FOUND;
        token_len = since_start - lp;
      end else if (since_start >= lp) begin
        take_token_char(recent[lp - 1]);
      end
    end
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      start_pat = '0;
      stop_pat  = '0;
      start_len = '0;
      stop_len  = '0;
      expected_fields.delete();
      clear_scan();
      n_mismatch = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_fields.size() == 0) begin
          $error("result beat with no expectation waiting: value %0d, outcome %0d",
                 $signed(out_mon.value), out_mon.outcome);
          n_mismatch++;
        end else begin
          want = expected_fields.pop_front();
          if (out_mon.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_mon.value));
            n_mismatch++;
          end
          if (out_mon.outcome !== want.outcome) begin
            $error("outcome mismatch: expected %0d, actual %0d", want.outcome, out_mon.outcome);
            n_mismatch++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) scan_char(in_mon.character);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_PATTERN: start_pat = cfg_wdata;
          REG_START_LENGTH:  start_len = cfg_wdata[LEN_W-1:0];
          REG_STOP_PATTERN:  stop_pat  = cfg_wdata;
          REG_STOP_LENGTH:   stop_len  = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches     <= n_mismatch;
    fields_pending <= expected_fields.size();
  end

endmodule

>>> tb/delimited_int16_field_extractor_tb.sv
module delimited_int16_field_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dife_pkg::*;
  import dife_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  recv_ready = 1'b0;
  int                    mismatches;
  int                    fields_pending;
  int unsigned           cycle_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_stall_pct = 0;
  int                    chars_sent = 0;

  logic [CFG_DATA_W-1:0] start_pat;
  logic [CFG_DATA_W-1:0] stop_pat;
  int                    start_n;
  int                    stop_n;
  logic [7:0]            text_q[$];

  dife_in_if  in_ch ();
  dife_out_if out_ch ();

  assign out_ch.ready = recv_ready;

  delimited_int16_field_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dife_field_checker field_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .fields_pending (fields_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    recv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** delimited_int16_field_extractor: FAILED **");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_queued();
    int i;
    for (i = 0; i < text_q.size(); i++) send_char(text_q[i]);
    text_q.delete();
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (fields_pending != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // registers change only with the block idle; length writes carry junk above the field
  task automatic set_delims(logic [CFG_DATA_W-1:0] sp, logic [LEN_W-1:0] sl,
                            logic [CFG_DATA_W-1:0] tp, logic [LEN_W-1:0] tl);
    logic [CFG_DATA_W-1:0] junk;
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    junk = {$urandom(), $urandom()};
    write_reg(REG_START_PATTERN, sp);
    write_reg(REG_START_LENGTH, {junk[CFG_DATA_W-1:LEN_W], sl});
    write_reg(REG_STOP_PATTERN, tp);
    junk = {$urandom(), $urandom()};
    write_reg(REG_STOP_LENGTH, {junk[CFG_DATA_W-1:LEN_W], tl});
    cfg_we    <= 1'b0;
    start_pat = sp;
    stop_pat  = tp;
    start_n   = delim_span(sp, sl);
    stop_n    = delim_span(tp, tl);
  endtask

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_noise(int n);
    int i;
    for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255, 1)));
  endfunction

  function automatic void push_spaces(int n);
    int i;
    int w;
    for (i = 0; i < n; i++) begin
      w = int'($urandom_range(13, 8));
      text_q.push_back((w == 8) ? CH_SPACE : 8'(w));
    end
  endfunction

  function automatic void push_delim(logic [CFG_DATA_W-1:0] pattern, int n);
    int i;
    for (i = 0; i < n; i++) text_q.push_back(pattern[8*i +: 8]);
  endfunction

  function automatic void push_number(bit broken);
    int          first;
    int          zeros;
    int          i;
    int unsigned mag;
    logic [7:0]  stray;
    logic [7:0]  digits[$];
    first = text_q.size();
    if ($urandom_range(3) == 0) push_spaces(int'($urandom_range(2, 1)));
    case ($urandom_range(2))
      1: text_q.push_back(CH_PLUS);
      2: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(3))
      0: mag = $urandom_range(9);
      1: mag = $urandom_range(999);
      2: mag = $urandom_range(32775, 32760);
      default: mag = $urandom_range(99999);
    endcase
    zeros = ($urandom_range(3) == 0) ? int'($urandom_range(3, 1)) : 0;
    for (i = 0; i < zeros; i++) text_q.push_back(CH_ZERO);
    do begin
      digits.push_front(CH_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    for (i = 0; i < digits.size(); i++) text_q.push_back(digits[i]);
    if (broken) begin
      case ($urandom_range(3))
        0: stray = 8'($urandom_range(255, 1));
        1: stray = CH_MINUS;
        2: stray = CH_SPACE;
        default: stray = CH_DOT;
      endcase
      text_q.insert(int'($urandom_range(text_q.size(), first)), stray);
    end
  endfunction

  function automatic void push_token();
    int k;
    int n;
    int i;
    k = int'($urandom_range(99));
    if (k < 55) push_number(1'b0);
    else if (k < 68) push_number(1'b1);
    else if (k < 74) begin
      push_spaces(int'($urandom_range(2)));
      if ($urandom_range(1) == 1) text_q.push_back(($urandom_range(1) == 1) ? CH_PLUS : CH_MINUS);
    end else if (k < 82) begin
      // long digit runs around the token length limit
      n = int'($urandom_range(36, 30));
      for (i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end else if (k >= 88) begin
      push_noise(int'($urandom_range(6, 1)));
    end
  endfunction

  task automatic send_string();
    int shape;
    shape = int'($urandom_range(99));
    if (start_n > 0) push_noise(int'($urandom_range(3)));
    if (shape < 95) push_delim(start_pat, start_n);
    push_token();
    if (shape < 88 || shape >= 95) push_delim(stop_pat, stop_n);
    if ($urandom_range(3) == 0) push_noise(int'($urandom_range(2, 1)));
    text_q.push_back(8'h00);
    send_queued();
  endtask

  task automatic run_phase(logic [CFG_DATA_W-1:0] sp, logic [LEN_W-1:0] sl,
                           logic [CFG_DATA_W-1:0] tp, logic [LEN_W-1:0] tl,
                           int idle_pct, int stall_pct, int budget);
    int first;
    set_delims(sp, sl, tp, tl);
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    first = chars_sent;
    while (chars_sent - first < budget) begin
      send_string();
      if ($urandom_range(9) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    start_pat       = '0;
    stop_pat        = '0;
    start_n         = 0;
    stop_n          = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset delimiters: bare terminator, then a field that is always empty
    text_q.push_back(8'h00);
    send_queued();
    push_text("7");
    text_q.push_back(8'h00);
    send_queued();

    set_delims(64'h3C, 4'd1, 64'h3E, 4'd1);
    push_text("<-32768>");
    text_q.push_back(8'h00);
    push_text("<+32767>");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    push_text("<x>");
    text_q.push_back(8'h00);
    send_queued();

    run_phase(64'h3C, 4'd1, 64'h3E, 4'd1, 0, 0, 140);
    run_phase(64'h1122_3344_3D4C_4156, 4'd4, 64'h3B, 4'd1, 52, 0, 140);
    run_phase(64'hDEAD_BEEF_0BAD_F00D, 4'd0, 64'h2C, 4'd1, 0, 52, 120);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h217E_405D_7C2A_265E, 4'd8, 34, 34, 160);
    // zero byte cuts both delimiters to two characters
    run_phase(64'h7777_7777_7700_2828, 4'd6, 64'h5A5A_5A5A_5A00_2929, 4'd15, 0, 0, 120);
    run_phase(64'h0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 52, 0, 40);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** delimited_int16_field_extractor: PASSED **");
    end else begin
      $display("** delimited_int16_field_extractor: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/dife_pkg.sv
rtl/core/dife_in_if.sv
rtl/core/dife_out_if.sv
rtl/core/delimited_int16_field_extractor.sv
tb/dife_tb_pkg.sv
tb/dife_field_checker.sv
tb/delimited_int16_field_extractor_tb.sv
